### rtl/assert_macros.svh
// Assertion macros used by the event flag table RTL.
// Each macro compiles to a concurrent assertion unless SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define EFST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define EFST_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EFST_ASSERT(lbl, clk, rst_n, prop, msg)
`define EFST_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/efst_pkg.sv
// Package for the event flag table: table size, request codes and the
// structs passed between the top level and the flag table. No dependencies.
`timescale 1ns / 1ps
package efst_pkg;

    localparam int NUM_FLAGS = 32;
    localparam int IDX_W = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
    localparam logic [8:0] NUM_FLAGS_CNT = 9'(NUM_FLAGS);

    localparam int AGE_W = 8;
    localparam logic [AGE_W-1:0] STALE_LIMIT_RESET = 8'd10;

    typedef enum logic [1:0] {
        REQ_RAISE = 2'd0,
        REQ_TAKE  = 2'd1,
        REQ_TICK  = 2'd2
    } req_code_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] req;
        logic [7:0] idx;
    } efst_op_t;

    typedef struct packed {
        logic was_raised;
        logic index_error;
    } efst_res_t;

endpackage

### rtl/event_flag_table_stale_clear.sv
// Event flag table with stale clearing: top level with the request and
// result registers. Depends on efst_pkg and efst_flag_table.
//
// Usage:
//   Requests arrive on the input channel (in_valid, in_ready, req_type,
//   action_index): raise sets a flag and zeroes its age, take reports and
//   clears a flag, tick ages every set flag and drops those that reach the
//   stale limit. Each request yields exactly one result transfer on the
//   output channel (out_valid, out_ready, was_raised, index_error).
//   The stale limit is written through cfg_we and cfg_wdata while idle.
//
//   An input transfer loads the request register; the table update and
//   lookup then load the result register, which raises out_valid. The
//   block takes one request per cycle while the receiver keeps up; a
//   stalled receiver holds the flow, as described below.
//
//   Reset clears all flags and ages and sets the stale limit to 10. When the
//   receiver stalls, the result register holds and one more request waits in
//   the request register; in_ready then drops until the result is taken.
`timescale 1ns / 1ps

module event_flag_table_stale_clear
    import efst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] action_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       was_raised,
    output logic       index_error
);

    logic [AGE_W-1:0] limit_reg;
    logic [AGE_W-1:0] limit_next;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [1:0]       s1_req_reg;
    logic [7:0]       s1_idx_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    efst_res_t        res_reg;

    logic             advance;
    efst_op_t         op;
    efst_res_t        res;

    // The result register can take a new value when empty or being drained.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;

    assign limit_next     = cfg_we ? cfg_wdata : limit_reg;
    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    // Only a request that moves into the result register touches the table.
    assign op.valid = s1_valid_reg && advance;
    assign op.req   = s1_req_reg;
    assign op.idx   = s1_idx_reg;

    efst_flag_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .stale_limit (limit_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= STALE_LIMIT_RESET;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            limit_reg       <= limit_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_req_reg <= req_type;
            s1_idx_reg <= action_index;
        end
        if (op.valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign was_raised  = res_reg.was_raised;
    assign index_error = res_reg.index_error;

endmodule

### rtl/efst_flag_table.sv
// Flag table state: one flag bit and one age counter per entry, updated by
// one request per cycle. Depends on efst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efst_flag_table
    import efst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  efst_op_t         op,
    input  logic [AGE_W-1:0] stale_limit,
    output efst_res_t        res
);

    logic [NUM_FLAGS-1:0] flag_bits_reg;
    logic [NUM_FLAGS-1:0] flag_bits_next;
    logic [AGE_W-1:0]     flag_ages_reg  [NUM_FLAGS];
    logic [AGE_W-1:0]     flag_ages_next [NUM_FLAGS];

    logic                 idx_ok;
    logic [IDX_W-1:0]     sel;
    logic [NUM_FLAGS-1:0] hit_vec;
    logic                 is_raise;
    logic                 is_take;
    logic                 is_tick;
    logic                 take_hit;
    logic [NUM_FLAGS-1:0] age_nz;

    assign idx_ok = ({1'b0, op.idx} < NUM_FLAGS_CNT);
    assign sel    = op.idx[IDX_W-1:0];

    always_comb
    begin
        is_raise = 1'b0;
        is_take  = 1'b0;
        is_tick  = 1'b0;
        case (op.req)
            REQ_RAISE: is_raise = op.valid;
            REQ_TAKE:  is_take  = op.valid;
            REQ_TICK:  is_tick  = op.valid;
            default:   ;
        endcase
    end

    assign take_hit = is_take && idx_ok;

    always_comb
    begin
        for (int i = 0; i < NUM_FLAGS; i++)
        begin
            hit_vec[i] = idx_ok && (sel == IDX_W'(i));
        end
    end

    // Every entry updates on its own; a tick ages all set flags at once.
    always_comb
    begin
        logic [AGE_W-1:0] age_inc;
        age_inc = '0;
        for (int i = 0; i < NUM_FLAGS; i++)
        begin
            flag_bits_next[i] = flag_bits_reg[i];
            flag_ages_next[i] = flag_ages_reg[i];
            age_inc = flag_ages_reg[i] + AGE_W'(1);
            if (is_tick && flag_bits_reg[i])
            begin
                if (age_inc >= stale_limit)
                begin
                    flag_bits_next[i] = 1'b0;
                    flag_ages_next[i] = '0;
                end
                else
                begin
                    flag_ages_next[i] = age_inc;
                end
            end
            else if ((is_raise || is_take) && hit_vec[i])
            begin
                flag_bits_next[i] = is_raise;
                flag_ages_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_bits_reg <= '0;
            for (int i = 0; i < NUM_FLAGS; i++)
            begin
                flag_ages_reg[i] <= '0;
            end
        end
        else
        begin
            flag_bits_reg <= flag_bits_next;
            for (int i = 0; i < NUM_FLAGS; i++)
            begin
                flag_ages_reg[i] <= flag_ages_next[i];
            end
        end
    end

    assign res.was_raised  = take_hit && flag_bits_reg[sel];
    assign res.index_error = (is_raise || is_take) && !idx_ok;

    always_comb
    begin
        for (int i = 0; i < NUM_FLAGS; i++)
        begin
            age_nz[i] = (flag_ages_reg[i] != '0);
        end
    end

    `EFST_NEVER(a_clear_flag_age_zero, clk, rst_n, |(~flag_bits_reg & age_nz), "clear flag has nonzero age")
    `EFST_NEVER(a_result_exclusive, clk, rst_n, res.was_raised && res.index_error, "raised and error together")
    `EFST_ASSERT(a_take_clears, clk, rst_n, take_hit |=> ((flag_bits_reg & $past(hit_vec)) == '0), "take left flag set")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for event_flag_table_stale_clear: raise, take and tick
// requests against an in-bench predictor of the flag table. Depends on efst_pkg.

module tb_top;
    import efst_pkg::*;

    // Request code that the package does not name; the block must answer it with
    // an all-zero result and leave the table alone.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Cycles without any transfer on either side before the run is declared hung.
    // The long receiver hold-off below is well under this.
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_ITEMS     = 80;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] req_type;
    logic [7:0] action_index;
    logic       out_valid;
    logic       out_ready;
    logic       was_raised;
    logic       index_error;

    // Predictor state: one flag bit and one age per table entry, plus the stale
    // limit as last written.
    bit         flag_set [NUM_FLAGS];
    logic [7:0] flag_age [NUM_FLAGS];
    logic [7:0] stale_limit_model;

    // Results that accepted requests are still owed, oldest first.
    efst_res_t  pending_results[$];

    int error_count;

    // Sender idling: when enabled, bursts of random length with random gaps.
    bit tx_idle_en;
    int tx_burst_left;

    // Receiver stalling: short random stall runs, or one long hold-off on demand.
    int rx_stall_pct;
    int rx_stall_left;
    int hold_off_len;

    event_flag_table_stale_clear DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .action_index (action_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .was_raised   (was_raised),
        .index_error  (index_error)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one accepted request to the predicted table and returns the result
    // the block owes for it. A tick ages every set flag and drops the ones whose
    // age reaches the stale limit; clear flags keep age zero.
    function automatic efst_res_t apply_flag_request(input logic [1:0] req,
                                                     input logic [7:0] idx);
        efst_res_t res;
        res = '0;
        case (req)
            REQ_RAISE, REQ_TAKE:
            begin
                if (idx >= NUM_FLAGS)
                begin
                    res.index_error = 1'b1;
                end
                else if (req == REQ_RAISE)
                begin
                    flag_set[idx] = 1'b1;
                    flag_age[idx] = '0;
                end
                else
                begin
                    res.was_raised = flag_set[idx];
                    flag_set[idx]  = 1'b0;
                    flag_age[idx]  = '0;
                end
            end
            REQ_TICK:
            begin
                for (int i = 0; i < NUM_FLAGS; i++)
                begin
                    if (flag_set[i])
                    begin
                        flag_age[i] = flag_age[i] + 8'd1;
                        if (flag_age[i] >= stale_limit_model)
                        begin
                            flag_set[i] = 1'b0;
                            flag_age[i] = '0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Offers one request and waits for its transfer. Valid stays high into the
    // next request unless the burst has run out, in which case the sender goes
    // quiet for a random gap. Must be entered right after a rising edge.
    task automatic send_request(input logic [1:0] req, input logic [7:0] idx);
        in_valid     <= 1'b1;
        req_type     <= req;
        action_index <= idx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_flag_request(req, idx));
        if (tx_idle_en)
        begin
            if (tx_burst_left > 0)
            begin
                tx_burst_left--;
            end
            else
            begin
                tx_burst_left = $urandom_range(0, 15);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Stops offering and waits until every owed result has been transferred.
    // Each request yields exactly one result, so an empty queue means the block
    // is idle; the extra wait covers its pipeline depth anyway.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes the stale limit. Only done with the block drained.
    task automatic set_stale_limit(input logic [7:0] value);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        stale_limit_model = value;
    endtask

    // Builds one random request. Most traffic addresses real flags, often a small
    // hot group so that takes find set flags; the rest is ticks, bad indexes and the
    // unused request code.
    task automatic send_random_request();
        int         pick;
        logic [7:0] idx;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0)
            idx = 8'($urandom_range(0, 7));
        else
            idx = 8'($urandom_range(0, NUM_FLAGS - 1));
        if (pick < 35)
            send_request(REQ_RAISE, idx);
        else if (pick < 65)
            send_request(REQ_TAKE, idx);
        else if (pick < 88)
            send_request(REQ_TICK, 8'($urandom_range(0, 255)));
        else if (pick < 94)
            send_request(($urandom_range(0, 1) == 0) ? REQ_RAISE : REQ_TAKE,
                         8'($urandom_range(NUM_FLAGS, 255)));
        else
            send_request(REQ_UNUSED, 8'($urandom_range(0, 255)));
    endtask

    // Edges of the index range, every request code, the ignored index on a tick,
    // re-raising a flag that is already set, and takes of flags never raised.
    task automatic test_directed_requests();
        tx_idle_en   = 1'b0;
        rx_stall_pct = 0;
        send_request(REQ_TAKE, 8'd0);
        send_request(REQ_RAISE, 8'd0);
        send_request(REQ_RAISE, 8'(NUM_FLAGS - 1));
        send_request(REQ_RAISE, 8'(NUM_FLAGS));
        send_request(REQ_RAISE, 8'hFF);
        send_request(REQ_TAKE, 8'hFF);
        send_request(REQ_TAKE, 8'(NUM_FLAGS));
        send_request(REQ_TICK, 8'hFF);
        send_request(REQ_TICK, 8'h00);
        send_request(REQ_RAISE, 8'd0);
        send_request(REQ_UNUSED, 8'h00);
        send_request(REQ_UNUSED, 8'hFF);
        send_request(REQ_UNUSED, 8'(NUM_FLAGS - 1));
        send_request(REQ_TAKE, 8'(NUM_FLAGS - 1));
        send_request(REQ_TAKE, 8'(NUM_FLAGS - 1));
        send_request(REQ_TAKE, 8'd0);
        send_request(REQ_RAISE, 8'h80);
        send_request(REQ_TAKE, 8'h7F);
        send_request(REQ_TAKE, 8'd1);
        wait_until_drained();
    endtask

    // Raises a few flags under the given stale limit and ticks them to just below
    // the limit and then once more, to reach it. Flag 7 is raised again halfway, which must
    // restart its age; flag 9 is never raised and must not age. A limit of zero
    // lies outside the normal range: the first tick then drops every set flag.
    task automatic test_stale_drop(input logic [7:0] limit);
        int below_limit;
        below_limit = (limit == 0) ? 0 : int'(limit) - 1;
        set_stale_limit(limit);
        send_request(REQ_RAISE, 8'd5);
        send_request(REQ_RAISE, 8'd6);
        send_request(REQ_RAISE, 8'd7);
        for (int n = 0; n < below_limit; n++)
        begin
            if (n == below_limit / 2)
                send_request(REQ_RAISE, 8'd7);
            send_request(REQ_TICK, 8'($urandom_range(0, 255)));
        end
        send_request(REQ_TAKE, 8'd5);
        send_request(REQ_TICK, 8'd0);
        send_request(REQ_TAKE, 8'd6);
        send_request(REQ_TAKE, 8'd7);
        send_request(REQ_TAKE, 8'd9);
        wait_until_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // back to back, so the result and request registers fill and in_ready drops.
    task automatic test_back_pressure();
        tx_idle_en   = 1'b0;
        rx_stall_pct = 0;
        hold_off_len = HOLD_OFF_CYCLES;
        for (int n = 0; n < 16; n++)
            send_random_request();
        wait_until_drained();
    endtask

    // Random traffic in phases, each under its own stale limit and idling mix.
    // The first phase runs with no idling on either side. Halfway through each
    // phase the sender pauses until every owed result has come back.
    task automatic test_random_traffic();
        logic [7:0] limits [4];
        limits[0] = 8'd3;
        limits[1] = 8'($urandom_range(1, 30));
        limits[2] = 8'($urandom_range(1, 255));
        limits[3] = 8'd2;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_stale_limit(limits[phase]);
            tx_idle_en    = (phase != 0);
            tx_burst_left = 0;
            rx_stall_pct  = (phase == 0) ? 0 : 10 * phase;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_until_drained();
                send_random_request();
            end
        end
        wait_until_drained();
    endtask

    // Receiver: ready by default, with short random stall runs when enabled and
    // one long hold-off when a test asks for it. Cycles are counted here so the
    // sender can keep pushing meanwhile.
    initial
    begin
        out_ready     = 1'b0;
        rx_stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                out_ready <= 1'b1;
            end
            else if (rx_stall_left > 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
                    rx_stall_left = $urandom_range(1, 4);
            end
        end
    end

    // Result checker: every result transfer is matched against the oldest
    // owed result, field by field.
    always @(posedge clk)
    begin : check_results
        efst_res_t wanted;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing owed: was_raised %0b index_error %0b",
                       was_raised, index_error);
                error_count++;
            end
            else
            begin
                wanted = pending_results.pop_front();
                if (was_raised !== wanted.was_raised)
                begin
                    $error("was_raised mismatch: expected %0b, actual %0b",
                           wanted.was_raised, was_raised);
                    error_count++;
                end
                if (index_error !== wanted.index_error)
                begin
                    $error("index_error mismatch: expected %0b, actual %0b",
                           wanted.index_error, index_error);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        req_type      = REQ_RAISE;
        action_index  = '0;
        error_count   = 0;
        tx_idle_en    = 1'b0;
        tx_burst_left = 0;
        rx_stall_pct  = 0;
        hold_off_len  = 0;
        for (int i = 0; i < NUM_FLAGS; i++)
        begin
            flag_set[i] = 1'b0;
            flag_age[i] = '0;
        end
        stale_limit_model = STALE_LIMIT_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_stale_drop(8'd10);
        test_stale_drop(8'd1);
        test_stale_drop(8'd0);
        test_stale_drop(8'd255);
        test_back_pressure();
        test_random_traffic();

        wait_until_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
